/* rtl/kti_pkg.sv */
// Shared types and constants for the keyframe track interpolator.
// No dependencies; imported by every module of the block.
`default_nettype none

package kti_pkg;

    // Request opcodes
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Result region codes
    localparam logic [1:0] REGION_BEFORE = 2'd0;
    localparam logic [1:0] REGION_LERP   = 2'd1;
    localparam logic [1:0] REGION_HOLD   = 2'd2;

    // Fraction is Q0.16: one quotient bit per divider step
    localparam int DIV_STEPS = 16;

    typedef struct packed {
        logic               opcode;
        logic [5:0]         key_index;
        logic [31:0]        key_time;
        logic signed [31:0] key_x;
        logic signed [31:0] key_y;
        logic signed [31:0] key_z;
        logic [31:0]        query_time;
    } kti_in_t;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic [5:0]         segment;
        logic [1:0]         region;
    } kti_out_t;

    // One row of the key memory
    typedef struct packed {
        logic [31:0] ktime;
        logic [31:0] kx;
        logic [31:0] ky;
        logic [31:0] kz;
    } kti_key_t;

    // Controller -> datapath
    typedef struct packed {
        logic load;       // write request key into memory
        logic q_start;    // latch query time and clamped key count
        logic rd;         // read next key row, shift previous row
        logic take_row;   // result is the current row as stored
        logic lerp_init;  // set up divider for the found segment
        logic div_step;   // one quotient bit
        logic mul;        // fraction times axis delta
        logic acc;        // add scaled delta to segment start
        logic emit;       // strobe result next cycle
    } kti_cmd_t;

    // Datapath -> controller
    typedef struct packed {
        logic lt;         // query time below current row time
        logic first;      // current row is key 0
        logic last;       // current row is the last key of the track
        logic div_last;   // final divider step
        logic axis_last;  // z axis in the multiply/add loop
    } kti_stat_t;

endpackage

`default_nettype wire

/* rtl/kti_ctrl.sv */
// Sequencer for the keyframe track interpolator: scan, divide, scale.
// Depends on kti_pkg (command and status structs).
`default_nettype none

module kti_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic              opcode,
    input  kti_pkg::kti_stat_t     st,
    output kti_pkg::kti_cmd_t      cmd,
    output logic                   busy
);
    import kti_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_FETCH = 6'b000010,
        ST_SCAN  = 6'b000100,
        ST_DIV   = 6'b001000,
        ST_MUL   = 6'b010000,
        ST_ACC   = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (opcode == OP_QUERY)
                    begin
                        cmd.q_start = 1'b1;
                        state_next  = ST_FETCH;
                    end
                    else
                    begin
                        cmd.load = 1'b1;
                    end
                end
            end
            ST_FETCH:
            begin
                cmd.rd     = 1'b1;
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (st.lt)
                begin
                    if (st.first)
                    begin
                        cmd.take_row = 1'b1;
                        cmd.emit     = 1'b1;
                        state_next   = ST_IDLE;
                    end
                    else
                    begin
                        cmd.lerp_init = 1'b1;
                        state_next    = ST_DIV;
                    end
                end
                else if (st.last)
                begin
                    cmd.take_row = 1'b1;
                    cmd.emit     = 1'b1;
                    state_next   = ST_IDLE;
                end
                else
                begin
                    cmd.rd = 1'b1;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (st.div_last)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                cmd.acc = 1'b1;
                if (st.axis_last)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_MUL;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != ST_IDLE);

`ifndef NO_ASSERTIONS
    // scan ends only through take_row or lerp_init, never by falling out
    a_scan_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN && !st.lt && !st.last) |=> (state_reg == ST_SCAN))
        else $error("scan left early");

    // lerp path always passes through the divider
    a_div_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MUL && $past(state_reg) != ST_ACC) |-> ($past(state_reg) == ST_DIV))
        else $error("multiply without divide");

    // result strobe only from scan or the final accumulate
    a_emit_src: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (state_reg == ST_SCAN || (state_reg == ST_ACC && st.axis_last)))
        else $error("stray emit");
`endif

endmodule

`default_nettype wire

/* rtl/kti_datapath.sv */
// Key memory, segment scan registers, radix-2 divider and scaling MAC.
// Depends on kti_pkg (payload, key row, command and status structs).
`default_nettype none

module kti_datapath #(
    parameter int MAX_KEYS = 64
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  kti_pkg::kti_in_t       request,
    input  wire logic              key_count_we,
    input  wire logic [6:0]        key_count,
    input  kti_pkg::kti_cmd_t      cmd,
    output kti_pkg::kti_stat_t     st,
    output kti_pkg::kti_out_t      result,
    output logic                   done
);
    import kti_pkg::*;

    localparam int AW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
    localparam int CW = $clog2(MAX_KEYS + 1);

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    // key memory: one write port (loads), one registered read port (scan)
    kti_key_t mem [MAX_KEYS];
    kti_key_t rd_reg;

    logic [6:0]          key_count_reg, key_count_next;
    logic                done_reg, done_next;
    logic [31:0]         t_reg, t_next;
    logic [CW-1:0]       n_reg, n_next;
    logic [CW-1:0]       idx_reg, idx_next;
    logic [CW-1:0]       cmp_idx_reg, cmp_idx_next;
    kti_key_t            prev_reg, prev_next;
    logic [31:0]         rem_reg, rem_next;
    logic [31:0]         dt_reg, dt_next;
    logic [15:0]         quo_reg, quo_next;
    logic [3:0]          div_cnt_reg, div_cnt_next;
    logic [1:0]          axis_reg, axis_next;
    logic signed [49:0]  prod_reg, prod_next;
    kti_out_t            res_reg, res_next;

    logic                wr_ok;
    logic [AW-1:0]       wr_addr;
    logic [AW-1:0]       rd_addr;
    logic [31:0]         kc_wide;
    logic [31:0]         n_wide;
    logic [32:0]         div_sh;
    logic [32:0]         div_sub;
    logic                div_ge;
    logic [31:0]         lo_v, hi_v;
    logic signed [32:0]  diff;
    logic [31:0]         acc_sum;

    assign wr_ok   = (32'(request.key_index) < 32'(MAX_KEYS));
    assign wr_addr = AW'(request.key_index);
    assign rd_addr = idx_reg[AW-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.load && wr_ok)
        begin
            mem[wr_addr] <= '{ktime: request.key_time,
                              kx:    request.key_x,
                              ky:    request.key_y,
                              kz:    request.key_z};
        end
        if (cmd.rd)
        begin
            rd_reg <= mem[rd_addr];
        end
    end

    // key count clamped to 1..MAX_KEYS
    assign kc_wide = 32'(key_count_reg);
    always_comb
    begin
        if (kc_wide == 32'd0)
        begin
            n_wide = 32'd1;
        end
        else if (kc_wide > 32'(MAX_KEYS))
        begin
            n_wide = 32'(MAX_KEYS);
        end
        else
        begin
            n_wide = kc_wide;
        end
    end

    // divider step: remainder stays below divisor
    assign div_sh  = {rem_reg, 1'b0};
    assign div_ge  = (div_sh >= {1'b0, dt_reg});
    assign div_sub = div_sh - {1'b0, dt_reg};

    // axis select for the shared multiplier
    always_comb
    begin
        case (axis_reg)
            AXIS_X:
            begin
                lo_v = prev_reg.kx;
                hi_v = rd_reg.kx;
            end
            AXIS_Y:
            begin
                lo_v = prev_reg.ky;
                hi_v = rd_reg.ky;
            end
            default:
            begin
                lo_v = prev_reg.kz;
                hi_v = rd_reg.kz;
            end
        endcase
    end

    assign diff    = $signed({hi_v[31], hi_v}) - $signed({lo_v[31], lo_v});
    // low word of start + floor(prod / 2^16)
    assign acc_sum = lo_v + prod_reg[47:16];

    assign st.lt        = (t_reg < rd_reg.ktime);
    assign st.first     = (cmp_idx_reg == '0);
    assign st.last      = (cmp_idx_reg == n_reg - 1'b1);
    assign st.div_last  = (div_cnt_reg == 4'(DIV_STEPS - 1));
    assign st.axis_last = (axis_reg == AXIS_Z);

    always_comb
    begin
        key_count_next = key_count_we ? key_count : key_count_reg;
        done_next      = cmd.emit;
        t_next         = t_reg;
        n_next         = n_reg;
        idx_next       = idx_reg;
        cmp_idx_next   = cmp_idx_reg;
        prev_next      = prev_reg;
        rem_next       = rem_reg;
        dt_next        = dt_reg;
        quo_next       = quo_reg;
        div_cnt_next   = div_cnt_reg;
        axis_next      = axis_reg;
        prod_next      = prod_reg;
        res_next       = res_reg;

        if (cmd.q_start)
        begin
            t_next   = request.query_time;
            n_next   = CW'(n_wide);
            idx_next = '0;
        end
        if (cmd.rd)
        begin
            idx_next     = idx_reg + 1'b1;
            cmp_idx_next = idx_reg;
            prev_next    = rd_reg;
        end
        if (cmd.take_row)
        begin
            res_next.out_x   = rd_reg.kx;
            res_next.out_y   = rd_reg.ky;
            res_next.out_z   = rd_reg.kz;
            res_next.segment = 6'(cmp_idx_reg);
            res_next.region  = st.lt ? REGION_BEFORE : REGION_HOLD;
        end
        if (cmd.lerp_init)
        begin
            rem_next         = t_reg - prev_reg.ktime;
            dt_next          = rd_reg.ktime - prev_reg.ktime;
            quo_next         = '0;
            div_cnt_next     = '0;
            axis_next        = AXIS_X;
            res_next.segment = 6'(cmp_idx_reg - 1'b1);
            res_next.region  = REGION_LERP;
        end
        if (cmd.div_step)
        begin
            rem_next     = div_ge ? div_sub[31:0] : div_sh[31:0];
            quo_next     = {quo_reg[14:0], div_ge};
            div_cnt_next = div_cnt_reg + 1'b1;
        end
        if (cmd.mul)
        begin
            prod_next = $signed({1'b0, quo_reg}) * diff;
        end
        if (cmd.acc)
        begin
            case (axis_reg)
                AXIS_X:  res_next.out_x = acc_sum;
                AXIS_Y:  res_next.out_y = acc_sum;
                default: res_next.out_z = acc_sum;
            endcase
            axis_next = axis_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_count_reg <= 7'd1;
            done_reg      <= 1'b0;
        end
        else
        begin
            key_count_reg <= key_count_next;
            done_reg      <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        t_reg       <= t_next;
        n_reg       <= n_next;
        idx_reg     <= idx_next;
        cmp_idx_reg <= cmp_idx_next;
        prev_reg    <= prev_next;
        rem_reg     <= rem_next;
        dt_reg      <= dt_next;
        quo_reg     <= quo_next;
        div_cnt_reg <= div_cnt_next;
        axis_reg    <= axis_next;
        prod_reg    <= prod_next;
        res_reg     <= res_next;
    end

    assign result = res_reg;
    assign done   = done_reg;

`ifndef NO_ASSERTIONS
    // scan never reads past the clamped track length
    a_rd_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd |-> (idx_reg < n_reg))
        else $error("key read beyond track");

    // divider invariant: remainder below divisor
    a_rem_lt: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_step |-> (rem_reg < dt_reg))
        else $error("divider remainder out of range");

    // an interpolation never starts at key 0, so its segment index does not wrap
    a_lerp_seg: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.lerp_init) |-> (cmp_idx_reg != '0))
        else $error("lerp from key zero");
`endif

endmodule

`default_nettype wire

/* rtl/keyframe_track_interpolator.sv */
// Keyframe track interpolator: sampled linear interpolation over a key track.
// Depends on kti_pkg, kti_ctrl and kti_datapath.
`default_nettype none

// A track holds up to MAX_KEYS keys (time in ticks, Q16.16 xyz), loaded by
// index in ascending time order. A request transfer is taken at a clock edge
// with start high and busy low. A load (opcode OP_LOAD) is written in that
// one edge, keeps busy low and gives no result. A query (OP_QUERY) raises busy
// and later gives exactly one result transfer: done is high for one cycle
// with result valid in that cycle, and the receiver cannot stall it. Busy is
// already low in the done cycle, so the next request can be taken then.
// A query scans the keys in order, one key per cycle through the single read
// port of the key memory. A query time before key 0 returns key 0, one at or
// after the last key returns that key (hold); otherwise the segment ending at
// the first later key is interpolated: a radix-2 divider produces the Q0.16
// fraction one bit per cycle, then one shared 17x33 multiplier does a multiply
// and an add step per axis. key_count (0..127, reset 1) is written through
// key_count_we; the user must write it only while idle, which the block does
// not enforce. 0 acts as 1, values above MAX_KEYS act as MAX_KEYS. Loads to
// slots at or above MAX_KEYS are dropped. Keys must be loaded before a query
// reaches them.

module keyframe_track_interpolator #(
    parameter int MAX_KEYS = 64
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  kti_pkg::kti_in_t       request,
    output logic                   done,
    output kti_pkg::kti_out_t      result,
    input  wire logic              key_count_we,
    input  wire logic [6:0]        key_count
);
    import kti_pkg::*;

    kti_cmd_t  cmd;
    kti_stat_t st;

    kti_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .opcode (request.opcode),
        .st     (st),
        .cmd    (cmd),
        .busy   (busy)
    );

    kti_datapath #(
        .MAX_KEYS (MAX_KEYS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .request      (request),
        .key_count_we (key_count_we),
        .key_count    (key_count),
        .cmd          (cmd),
        .st           (st),
        .result       (result),
        .done         (done)
    );

`ifndef NO_ASSERTIONS
    // result transfer lands with the block idle again
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("done while busy");

    // an accepted query occupies the block
    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && request.opcode == OP_QUERY) |=> busy)
        else $error("query not started");

    // a load completes in its accepting edge and gives no result
    a_load_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && request.opcode == OP_LOAD) |=> (!busy && !done))
        else $error("load misbehaved");

    // one strobe per query
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("repeated done");
`endif

endmodule

`default_nettype wire
